// ===== src/h264rtp_pkg.sv =====
// Shared types and constants of the H.264 RTP NAL packetizer.
`default_nettype none
package h264rtp_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MPS  = 2'd1;

  localparam logic        MODE_RESET = 1'b1;
  localparam logic [15:0] MPS_RESET  = 16'd1400;

  localparam logic [4:0] FUA_TYPE = 5'd28;
  localparam logic [7:0] NRI_MASK = 8'h60;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] nal_length;
    logic        last_nal_in_frame;
    logic [31:0] rtp_timestamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_start;
    logic        packet_end;
    logic        marker;
    logic [15:0] sequence_number;
    logic [31:0] timestamp_out;
  } out_item_t;

  typedef struct packed {
    logic        packetization_mode;
    logic [15:0] max_payload_size;
  } cfg_t;

  typedef struct packed {
    logic [15:0] byte_index;
    logic [15:0] chunk_fill;
    logic [7:0]  saved_header;
    logic        fragmenting;
    logic [15:0] sequence_counter;
  } state_t;

  // results caused by one NAL byte, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]                  cnt;
    out_item_t [MAX_RESULTS-1:0]       item;
  } group_t;

endpackage : h264rtp_pkg
`default_nettype wire

// ===== src/h264rtp_step.sv =====
// Per-byte packetizing logic: next state and the result group for one NAL byte.
`default_nettype none
module h264rtp_step (
  input  h264rtp_pkg::cfg_t     cfg,
  input  h264rtp_pkg::state_t   st,
  input  h264rtp_pkg::in_item_t item,
  output h264rtp_pkg::state_t   st_nxt,
  output h264rtp_pkg::group_t   grp
);
  import h264rtp_pkg::*;

  logic        first_byte;
  logic        nal_end;
  logic [15:0] pm;
  logic [7:0]  hdr_e;
  logic        frag_e;
  logic [15:0] fill_e;
  logic [15:0] chunk_start;
  logic        final_chunk;
  logic        chunk_full;
  logic        pkt_end;
  logic        mk;
  logic [7:0]  fu_ind;
  logic [7:0]  fu_hdr;
  logic [CNT_W-1:0] last_slot;
  out_item_t   base;

  assign first_byte  = (st.byte_index == 16'd0);
  assign nal_end     = ({1'b0, st.byte_index} + 17'd1) >= {1'b0, item.nal_length};
  assign pm          = (cfg.max_payload_size < 16'd3) ? 16'd1
                                                       : cfg.max_payload_size - 16'd2;
  assign hdr_e       = first_byte ? item.data_byte : st.saved_header;
  assign frag_e      = first_byte ? (cfg.packetization_mode &&
                                     (item.nal_length > cfg.max_payload_size))
                                  : st.fragmenting;
  assign fill_e      = first_byte ? 16'd0 : st.chunk_fill;
  assign chunk_start = st.byte_index - fill_e;
  assign final_chunk = ({1'b0, chunk_start} + {1'b0, pm}) >= {1'b0, item.nal_length};
  assign chunk_full  = ({1'b0, fill_e} + 17'd1) >= {1'b0, pm};
  assign pkt_end     = nal_end || (frag_e && chunk_full);
  assign mk          = frag_e ? (item.last_nal_in_frame && final_chunk)
                              : item.last_nal_in_frame;
  assign fu_ind      = (hdr_e & NRI_MASK) | {3'b000, FUA_TYPE};
  assign fu_hdr      = {(chunk_start == 16'd0), final_chunk, 1'b0, hdr_e[4:0]};

  always_comb begin
    base.out_byte        = item.data_byte;
    base.packet_start    = 1'b0;
    base.packet_end      = 1'b0;
    base.marker          = mk;
    base.sequence_number = st.sequence_counter;
    base.timestamp_out   = item.rtp_timestamp;

    grp.item[0] = base;
    grp.item[1] = base;
    grp.item[2] = base;

    if (!frag_e) begin
      grp.cnt = 2'd1;
      grp.item[0].packet_start = first_byte;
    end else if (fill_e == 16'd0) begin
      // open a chunk: FU indicator, FU header, then the byte unless it is the header
      grp.item[0].out_byte     = fu_ind;
      grp.item[0].packet_start = 1'b1;
      grp.item[1].out_byte     = fu_hdr;
      grp.cnt = first_byte ? 2'd2 : 2'd3;
    end else begin
      grp.cnt = 2'd1;
    end

    last_slot = grp.cnt - 2'd1;
    grp.item[last_slot].packet_end = pkt_end;
  end

  always_comb begin
    st_nxt.byte_index       = nal_end ? 16'd0 : st.byte_index + 16'd1;
    st_nxt.chunk_fill       = frag_e ? (pkt_end ? 16'd0 : fill_e + 16'd1) : fill_e;
    st_nxt.saved_header     = hdr_e;
    st_nxt.fragmenting      = frag_e;
    st_nxt.sequence_counter = st.sequence_counter + {15'd0, pkt_end};
  end

endmodule : h264rtp_step
`default_nettype wire

// ===== src/h264_rtp_nal_packetizer_unit.sv =====
// Top level of the H.264 RTP NAL packetizer with FU-A fragmentation.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------
//   in_      | input     | in_valid / in_stall    | in_data  (in_item_t)
//   out_     | output    | out_valid / out_stall  | out_data (out_item_t)
//   cfg_     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_wdata
//
// Results: a pass-through byte or a byte inside an FU-A chunk gives one result,
// the header byte of a fragmented NAL two and a chunk-opening byte three; the
// single result port drains the result group. A request passes the input
// register and then the result group register; its first result is shown
// once the result register is free.
// Reset: synchronous, active low; clears the pipeline, the packetizer state and
// loads packetization_mode = 1, max_payload_size = 1400.
// Stalls: out_stall holds the result group; the input register keeps taking
// one request while a result waits, then in_stall rises.
`default_nettype none
module h264_rtp_nal_packetizer_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  // byte input
  input  wire                               in_valid,
  output logic                              in_stall,
  input  h264rtp_pkg::in_item_t             in_data,
  // result output
  output logic                              out_valid,
  input  wire                               out_stall,
  output h264rtp_pkg::out_item_t            out_data,
  // register writes
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [h264rtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [15:0]                        cfg_wdata
);
  import h264rtp_pkg::*;

  // input register
  logic                        s1_valid_r;
  in_item_t                    s1_item_r;
  // result group register, slot 0 is presented
  logic [CNT_W-1:0]            rem_r;
  out_item_t [MAX_RESULTS-1:0] items_r;
  // packetizer state and registers
  state_t                      st_r;
  state_t                      st_nxt;
  cfg_t                        cfg_r;
  group_t                      grp;

  logic in_take;
  logic out_take;
  logic s2_load;

  assign out_valid = (rem_r != '0);
  assign out_data  = items_r[0];
  assign out_take  = out_valid && !out_stall;

  // move the held request on once the group is empty or its last result leaves
  assign s2_load   = s1_valid_r && ((rem_r == '0) || ((rem_r == 2'd1) && out_take));
  assign in_stall  = s1_valid_r && !s2_load;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  h264rtp_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .grp    (grp)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      rem_r      <= '0;
      st_r       <= '0;
      cfg_r.packetization_mode <= MODE_RESET;
      cfg_r.max_payload_size   <= MPS_RESET;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end

      if (s2_load) begin
        rem_r <= grp.cnt;
        st_r  <= st_nxt;
      end else if (out_take) begin
        rem_r <= rem_r - 2'd1;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDX_MODE: cfg_r.packetization_mode <= cfg_wdata[0];
          CFG_IDX_MPS:  cfg_r.max_payload_size   <= cfg_wdata;
          default:      ;
        endcase
      end
    end
  end

  // payload: hold while stalled, advance on a take
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (s2_load) begin
      items_r <= grp.item;
    end else if (out_take) begin
      items_r[0] <= items_r[1];
      items_r[1] <= items_r[2];
    end
  end

endmodule : h264_rtp_nal_packetizer_unit
`default_nettype wire

// ===== src/h264rtp_checker.sv =====
// Port-level checker of the packetizer, bound to the top level.
`default_nettype none
module h264rtp_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     out_valid,
  input wire                     out_stall,
  input h264rtp_pkg::out_item_t  out_data
);
  import h264rtp_pkg::*;

  logic out_take;
  assign out_take = out_valid && !out_stall;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // reset empties the result group
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // back-to-back results inside one packet share the sequence number
  a_seq_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !out_data.packet_end) ##1 out_take |->
      (out_data.sequence_number == $past(out_data.sequence_number)))
    else $error("sequence number changed inside a packet");

  // the packet after a packet end takes the next sequence number
  a_seq_next: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_data.packet_end) ##1 out_take |->
      (out_data.packet_start &&
       (out_data.sequence_number == $past(out_data.sequence_number) + 16'd1)))
    else $error("sequence number did not advance");

endmodule : h264rtp_checker

bind h264_rtp_nal_packetizer_unit h264rtp_checker u_h264rtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
